// File: rtl/cdgm_pkg.sv
// Package for the central-difference gradient magnitude unit.
// Holds the shared types, register codes and default sizes. No dependencies.
package cdgm_pkg;

    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int IN_PIXEL_BITS  = 16;
    localparam int CFG_BITS       = 11;
    localparam int CFG_IDX_BITS   = 2;
    localparam int POS_BITS       = 10;
    localparam int MAG_BITS       = 18;

    localparam logic [CFG_BITS-1:0]     CFG_DIM_RESET    = 11'd1024;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_ROOT,
        ST_PUT,
        ST_WRITE
    } state_t;

    // which result of a transaction is being worked on
    typedef enum logic [1:0] {
        K_PREV,
        K_EDGE,
        K_FINAL
    } kind_t;

endpackage

// File: rtl/cdgm_store.sv
// Column store: simple dual-port synchronous RAM with a registered read.
// Depends on nothing; sized by its parameters.
module cdgm_store #(
    parameter int DEPTH = 2048,
    parameter int DW    = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/cdgm_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on nothing; width of the radicand is a parameter.
module cdgm_sqrt #(
    parameter int VW = 35,
    localparam int N = (VW + 1) / 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VW-1:0] value,
    output logic          done,
    output logic [N-1:0]  root
);

    localparam int TW = VW + 1;
    localparam int CNW = $clog2(N + 1);

    logic [TW-1:0]  rem_reg, res_reg, bit_reg;
    logic [TW-1:0]  sum;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg, done_reg;

    assign sum  = res_reg + bit_reg;
    assign done = done_reg;
    assign root = res_reg[N-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= TW'(value);
            res_reg <= '0;
            bit_reg <= TW'(1) << (2 * (N - 1));
        end
        else if (busy_reg)
        begin
            if (rem_reg >= sum)
            begin
                rem_reg <= rem_reg - sum;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// File: rtl/central_difference_gradient_magnitude_unit.sv
// Each result runs through the operand reads, three arithmetic states (difference, square,
// sum), the bit-serial root and the hand-off; a store write follows the previous-column result
// (in column 0, the transaction) and precedes any last-column results; a transaction with no
// result only writes the store. in_stall is high until a transaction is through, so the single
// RAM read port and the bit-serial root set the pace. Reset clears counters, state and output
// valid; sizes reset to 1024; RAM is not cleared. Uses cdgm_pkg/store/sqrt.
module central_difference_gradient_magnitude_unit #(
    parameter int MAX_HEIGHT = cdgm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = cdgm_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = cdgm_pkg::DEF_PIXEL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cdgm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cdgm_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cdgm_pkg::IN_PIXEL_BITS-1:0] pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cdgm_pkg::POS_BITS-1:0]     column,
    output logic [cdgm_pkg::POS_BITS-1:0]     row,
    output logic [cdgm_pkg::MAG_BITS-1:0]     magnitude,
    output logic                              last
);

    localparam int P   = PIXEL_BITS;
    localparam int AHW = $clog2(MAX_HEIGHT);
    localparam int AW  = AHW + 1;
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int VW  = 2 * P + 3;
    localparam int N   = (VW + 1) / 2;

    cdgm_pkg::state_t state_reg, state_next;
    cdgm_pkg::kind_t  kind_reg;

    logic [cdgm_pkg::CFG_BITS-1:0] width_reg, height_reg;
    logic [CW-1:0]  eff_w, cnt_c_reg, acc_c, cur_c_reg, nc;
    logic [HCW-1:0] eff_h, cnt_r_reg, acc_r, cur_r_reg, nr;
    logic [HCW-1:0] r_m1, r_m2, r_p1;
    logic [P-1:0]   pix_reg;
    logic [P-1:0]   op_reg [4];
    logic [2:0]     k_reg;
    logic [P-1:0]   ctr, lv, rv, uv, dv;
    logic [P-1:0]   dw_reg, dh_reg;
    logic [2*P-1:0] sqw_reg, sqh_reg;
    logic [VW-1:0]  rad;
    logic [N-1:0]   root;
    logic [N-1:0]   root_reg;
    logic           sq_done;
    logic           acc, out_free, last_col, have_b, have_c, c0;
    logic           mem_we, sq_start;
    logic [AW-1:0]  raddr, waddr;
    logic [P-1:0]   rdata;

    // effective frame size
    always_comb
    begin
        if (width_reg == '0)
            eff_w = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(width_reg);
        if (height_reg == '0)
            eff_h = HCW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = HCW'(MAX_HEIGHT);
        else
            eff_h = HCW'(height_reg);
    end

    assign acc      = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;

    always_comb
    begin
        if (cnt_c_reg >= eff_w || cnt_r_reg >= eff_h)
        begin
            acc_c = '0;
            acc_r = '0;
        end
        else
        begin
            acc_c = cnt_c_reg;
            acc_r = cnt_r_reg;
        end
        nc = acc_c;
        nr = acc_r + HCW'(1);
        if (nr >= eff_h)
        begin
            nr = '0;
            nc = acc_c + CW'(1);
            if (nc >= eff_w)
                nc = '0;
        end
    end

    assign last_col = (cur_c_reg == eff_w - CW'(1));
    assign have_b   = (cur_r_reg != '0);
    assign have_c   = (cur_r_reg == eff_h - HCW'(1));
    assign c0       = cur_c_reg[0];
    assign r_m1     = cur_r_reg - HCW'(1);
    assign r_m2     = cur_r_reg - HCW'(2);
    assign r_p1     = cur_r_reg + HCW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdgm_pkg::ST_IDLE:
                if (acc)
                    state_next = (acc_c != '0) ? cdgm_pkg::ST_READ : cdgm_pkg::ST_WRITE;
            cdgm_pkg::ST_READ:
                if (k_reg == 3'd4)
                    state_next = cdgm_pkg::ST_DIFF;
            cdgm_pkg::ST_DIFF:
                state_next = cdgm_pkg::ST_MUL;
            cdgm_pkg::ST_MUL:
                state_next = cdgm_pkg::ST_SUM;
            cdgm_pkg::ST_SUM:
                state_next = cdgm_pkg::ST_ROOT;
            cdgm_pkg::ST_ROOT:
                if (sq_done)
                    state_next = cdgm_pkg::ST_PUT;
            cdgm_pkg::ST_PUT:
                if (out_free)
                begin
                    case (kind_reg)
                        cdgm_pkg::K_PREV:
                            state_next = cdgm_pkg::ST_WRITE;
                        cdgm_pkg::K_EDGE:
                            state_next = have_c ? cdgm_pkg::ST_READ : cdgm_pkg::ST_IDLE;
                        default:
                            state_next = cdgm_pkg::ST_IDLE;
                    endcase
                end
            cdgm_pkg::ST_WRITE:
                state_next = (last_col && (have_b || have_c)) ?
                             cdgm_pkg::ST_READ : cdgm_pkg::ST_IDLE;
            default:
                state_next = cdgm_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall = (state_reg != cdgm_pkg::ST_IDLE);
        mem_we   = (state_reg == cdgm_pkg::ST_WRITE);
        sq_start = (state_reg == cdgm_pkg::ST_SUM);
        waddr    = {c0, cur_r_reg[AHW-1:0]};
        case (kind_reg)
            cdgm_pkg::K_PREV:
                case (k_reg)
                    3'd0:    raddr = {~c0, cur_r_reg[AHW-1:0]};
                    3'd1:    raddr = {c0, cur_r_reg[AHW-1:0]};
                    3'd2:    raddr = {~c0, r_m1[AHW-1:0]};
                    default: raddr = {~c0, r_p1[AHW-1:0]};
                endcase
            cdgm_pkg::K_EDGE:
                case (k_reg)
                    3'd0:    raddr = {c0, r_m1[AHW-1:0]};
                    3'd1:    raddr = {~c0, r_m1[AHW-1:0]};
                    default: raddr = {c0, r_m2[AHW-1:0]};
                endcase
            default:
                case (k_reg)
                    3'd1:    raddr = {~c0, cur_r_reg[AHW-1:0]};
                    default: raddr = {c0, r_m1[AHW-1:0]};
                endcase
        endcase
    end

    // operand selection with edge clamping
    always_comb
    begin
        ctr = (kind_reg == cdgm_pkg::K_FINAL) ? pix_reg : op_reg[0];
        rv  = (kind_reg == cdgm_pkg::K_EDGE) ? ctr : pix_reg;
        case (kind_reg)
            cdgm_pkg::K_PREV:
            begin
                lv = (cur_c_reg >= CW'(2)) ? op_reg[1] : ctr;
                uv = have_b ? op_reg[2] : ctr;
                dv = (r_p1 < eff_h) ? op_reg[3] : ctr;
            end
            cdgm_pkg::K_EDGE:
            begin
                lv = (cur_c_reg != '0) ? op_reg[1] : ctr;
                uv = (cur_r_reg >= HCW'(2)) ? op_reg[2] : ctr;
                dv = pix_reg;
            end
            default:
            begin
                lv = (cur_c_reg != '0) ? op_reg[1] : ctr;
                uv = have_b ? op_reg[2] : ctr;
                dv = pix_reg;
            end
        endcase
    end

    assign rad = {({1'b0, sqw_reg} + {1'b0, sqh_reg}), 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cdgm_pkg::ST_IDLE;
            kind_reg   <= cdgm_pkg::K_PREV;
            k_reg      <= '0;
            cnt_c_reg  <= '0;
            cnt_r_reg  <= '0;
            width_reg  <= cdgm_pkg::CFG_DIM_RESET;
            height_reg <= cdgm_pkg::CFG_DIM_RESET;
            out_valid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= (state_reg == cdgm_pkg::ST_READ) ? k_reg + 3'd1 : 3'd0;
            if (cfg_we && (cfg_index == cdgm_pkg::REG_IMAGE_WIDTH ||
                           cfg_index == cdgm_pkg::REG_IMAGE_HEIGHT))
            begin
                if (cfg_index == cdgm_pkg::REG_IMAGE_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
                cnt_c_reg <= '0;
                cnt_r_reg <= '0;
            end
            else if (acc)
            begin
                cnt_c_reg <= nc;
                cnt_r_reg <= nr;
            end
            if (acc)
                kind_reg <= cdgm_pkg::K_PREV;
            else if (state_reg == cdgm_pkg::ST_WRITE)
                kind_reg <= have_b ? cdgm_pkg::K_EDGE : cdgm_pkg::K_FINAL;
            else if (state_reg == cdgm_pkg::ST_PUT && out_free &&
                     kind_reg == cdgm_pkg::K_EDGE)
                kind_reg <= cdgm_pkg::K_FINAL;
            if (state_reg == cdgm_pkg::ST_PUT && out_free)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cur_c_reg <= acc_c;
            cur_r_reg <= acc_r;
            pix_reg   <= P'(pixel);
        end
        if (state_reg == cdgm_pkg::ST_READ && k_reg != 3'd0)
            op_reg[2'(k_reg - 3'd1)] <= rdata;
        if (state_reg == cdgm_pkg::ST_DIFF)
        begin
            dw_reg <= (rv >= lv) ? rv - lv : lv - rv;
            dh_reg <= (uv >= dv) ? uv - dv : dv - uv;
        end
        if (state_reg == cdgm_pkg::ST_MUL)
        begin
            sqw_reg <= dw_reg * dw_reg;
            sqh_reg <= dh_reg * dh_reg;
        end
        if (sq_done)
            root_reg <= root;
        if (state_reg == cdgm_pkg::ST_PUT && out_free)
        begin
            magnitude <= cdgm_pkg::MAG_BITS'(root_reg);
            case (kind_reg)
                cdgm_pkg::K_PREV:
                begin
                    column <= cdgm_pkg::POS_BITS'(cur_c_reg - CW'(1));
                    row    <= cdgm_pkg::POS_BITS'(cur_r_reg);
                    last   <= !(last_col && (have_b || have_c));
                end
                cdgm_pkg::K_EDGE:
                begin
                    column <= cdgm_pkg::POS_BITS'(cur_c_reg);
                    row    <= cdgm_pkg::POS_BITS'(r_m1);
                    last   <= !have_c;
                end
                default:
                begin
                    column <= cdgm_pkg::POS_BITS'(cur_c_reg);
                    row    <= cdgm_pkg::POS_BITS'(cur_r_reg);
                    last   <= 1'b1;
                end
            endcase
        end
    end

    // two slots of 2**AHW rows, addressed {column parity, row}
    cdgm_store #(
        .DEPTH (2 ** AW),
        .DW    (P)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (pix_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    cdgm_sqrt #(
        .VW (VW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (rad),
        .done  (sq_done),
        .root  (root)
    );

endmodule

// File: rtl/cdgm_checker.sv
// Port-level checks for the gradient magnitude unit, bound to the top level.
// Depends on cdgm_pkg.
module cdgm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [cdgm_pkg::POS_BITS-1:0] column,
    input logic [cdgm_pkg::POS_BITS-1:0] row,
    input logic [cdgm_pkg::MAG_BITS-1:0] magnitude,
    input logic                          last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(column) && $stable(row) &&
                                   $stable(magnitude) && $stable(last))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("transaction accepted without going busy");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

endmodule

bind central_difference_gradient_magnitude_unit cdgm_checker u_cdgm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .column    (column),
    .row       (row),
    .magnitude (magnitude),
    .last      (last)
);
